@@ rtl/tkns_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkns_pkg
// Shared types and constants for the top-k nearest neighbour selector.
// ----------------------------------------------------------------------------
package tkns_pkg;

  localparam int MAX_K = 64;
  localparam int CNT_W = $clog2(MAX_K + 1);

  // input commands, carried on in_tuser
  localparam logic [1:0] CMD_BEGIN  = 2'd0;
  localparam logic [1:0] CMD_OFFER  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // per-cycle chain operations
  localparam logic [1:0] OP_HOLD    = 2'd0;  // keep contents
  localparam logic [1:0] OP_INSERT  = 2'd1;  // sorted insert, tail grows
  localparam logic [1:0] OP_REPLACE = 2'd2;  // drop head, sorted insert
  localparam logic [1:0] OP_SHIFT   = 2'd3;  // drop head, shift toward head

  typedef struct packed {
    logic [31:0] distance;
    logic [31:0] idx;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    entry_t     cand;
  } cell_ctl_t;

endpackage

@@ rtl/top_k_nearest_selector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_nearest_selector_unit
// Keeps the k nearest candidates of a query in a sorted chain of cells and
// emits them furthest to nearest on finish.
// ----------------------------------------------------------------------------
// Begin and offer requests: one per cycle, settled in the cycle they are taken.
// Finish: n held entries leave the chain head one per cycle while the output is not
//   stalled, through the output register; no input request is taken while draining.
// Reset (rst_n low, synchronous): fill count and query id zero, k = 32,
//   output empty; the entry cells are not cleared.
module top_k_nearest_selector_unit import tkns_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: k_in_use
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] item_id, [63:32] distance
  input  logic [1:0]  in_tuser,   // [1:0] command
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] neighbour_index, [63:32] neighbour_distance
  output logic        out_tlast   // last_of_run
);

  logic [6:0]       k_r,       k_nxt;
  logic [CNT_W-1:0] count_r,   count_nxt;
  logic [31:0]      query_r,   query_nxt;
  logic             drain_r,   drain_nxt;
  logic             ovalid_r,  ovalid_nxt;
  entry_t           oent_r,    oent_nxt;
  logic             olast_r,   olast_nxt;

  logic [CNT_W-1:0] k_eff;
  logic             acc;
  logic             pop;
  logic [1:0]       cmd;
  logic [31:0]      in_id;
  logic [31:0]      in_dist;
  cell_ctl_t        ctl;
  entry_t           head;

  assign cmd     = in_tuser;
  assign in_id   = in_tdata[31:0];
  assign in_dist = in_tdata[63:32];

  assign cfg_ready = 1'b1;
  assign in_tready = !drain_r;
  assign acc       = in_tvalid && in_tready;
  assign pop       = drain_r && (!ovalid_r || out_tready);
  assign k_eff     = (k_r > 7'(MAX_K)) ? CNT_W'(MAX_K) : CNT_W'(k_r);

  always_comb begin
    ctl.op            = OP_HOLD;
    ctl.cand.distance = in_dist;
    ctl.cand.idx      = in_id - 32'd1;
    if (pop) begin
      ctl.op = OP_SHIFT;
    end else if (acc && cmd == CMD_OFFER && in_id != query_r) begin
      if (count_r < k_eff) begin
        ctl.op = OP_INSERT;
      end else if (count_r != '0 && head.distance > in_dist) begin
        ctl.op = OP_REPLACE;
      end
    end
  end

  tkns_chain u_chain (
    .clk     (clk),
    .count_i (count_r),
    .ctl_i   (ctl),
    .head_o  (head)
  );

  always_comb begin
    k_nxt      = k_r;
    count_nxt  = count_r;
    query_nxt  = query_r;
    drain_nxt  = drain_r;
    ovalid_nxt = ovalid_r;
    oent_nxt   = oent_r;
    olast_nxt  = olast_r;

    if (cfg_valid) begin
      k_nxt = cfg_data;
    end

    if (ctl.op == OP_INSERT) begin
      count_nxt = count_r + CNT_W'(1);
    end

    if (acc) begin
      case (cmd)
        CMD_BEGIN: begin
          count_nxt = '0;
          query_nxt = in_id;
        end
        CMD_FINISH: begin
          if (count_r != '0) begin
            drain_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (pop) begin
      ovalid_nxt = 1'b1;
      oent_nxt   = head;
      olast_nxt  = (count_r == CNT_W'(1));
      count_nxt  = count_r - CNT_W'(1);
      if (count_r == CNT_W'(1)) begin
        drain_nxt = 1'b0;
      end
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r      <= 7'd32;
      count_r  <= '0;
      query_r  <= '0;
      drain_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      k_r      <= k_nxt;
      count_r  <= count_nxt;
      query_r  <= query_nxt;
      drain_r  <= drain_nxt;
      ovalid_r <= ovalid_nxt;
    end
    oent_r  <= oent_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {oent_r.distance, oent_r.idx};
  assign out_tlast  = olast_r;

endmodule

@@ rtl/tkns_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkns_cell
// One slot of the sorted chain. Holds an entry and moves it with its
// neighbors; the chain stays sorted furthest-first.
// ----------------------------------------------------------------------------
module tkns_cell import tkns_pkg::*; (
  input  logic      clk,
  input  logic      valid_i,     // slot lies below the fill count
  input  cell_ctl_t ctl_i,
  input  logic      left_gt_i,   // left neighbor ranks above candidate
  input  logic      right_gt_i,  // right neighbor ranks above candidate
  input  entry_t    left_i,
  input  entry_t    right_i,
  output logic      gt_o,
  output entry_t    ent_o
);

  entry_t ent_r;
  entry_t ent_nxt;

  // packed compare ranks by distance, then by index
  assign gt_o  = valid_i && (ent_r > ctl_i.cand);
  assign ent_o = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    case (ctl_i.op)
      OP_INSERT: begin
        if (!gt_o) begin
          ent_nxt = left_gt_i ? ctl_i.cand : left_i;
        end
      end
      OP_REPLACE: begin
        if (right_gt_i) begin
          ent_nxt = right_i;
        end else if (gt_o) begin
          ent_nxt = ctl_i.cand;
        end
      end
      OP_SHIFT: ent_nxt = right_i;
      default:  ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

@@ rtl/tkns_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkns_chain
// Row of MAX_K cells, furthest entry at slot 0. Exposes the head entry.
// ----------------------------------------------------------------------------
module tkns_chain import tkns_pkg::*; (
  input  logic             clk,
  input  logic [CNT_W-1:0] count_i,
  input  cell_ctl_t        ctl_i,
  output entry_t           head_o
);

  logic   gt   [MAX_K];
  entry_t ent  [MAX_K];

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic   left_gt;
    logic   right_gt;
    entry_t left_e;
    entry_t right_e;

    if (i == 0) begin : g_first
      // nothing ranks above the head, so it acts as a greater sentinel
      assign left_gt = 1'b1;
      assign left_e  = '0;
    end else begin : g_mid_l
      assign left_gt = gt[i-1];
      assign left_e  = ent[i-1];
    end

    if (i == MAX_K - 1) begin : g_last
      assign right_gt = 1'b0;
      assign right_e  = '0;
    end else begin : g_mid_r
      assign right_gt = gt[i+1];
      assign right_e  = ent[i+1];
    end

    tkns_cell u_cell (
      .clk        (clk),
      .valid_i    (count_i > CNT_W'(i)),
      .ctl_i      (ctl_i),
      .left_gt_i  (left_gt),
      .right_gt_i (right_gt),
      .left_i     (left_e),
      .right_i    (right_e),
      .gt_o       (gt[i]),
      .ent_o      (ent[i])
    );
  end

  assign head_o = ent[0];

endmodule

@@ tb/tb_top_k_nearest_selector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_nearest_selector_unit
// Self-checking bench for the top-k nearest selector. Begin, offer and finish
// requests go in on the stream input; k is rewritten between and within phases.
// A scoreboard keeps its own copy of the held neighbours and queues the
// furthest-to-nearest results that each finish must produce. Every result
// that leaves the block is compared with the oldest queued one, field by
// field. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_top_k_nearest_selector_unit;
  import tkns_pkg::*;

  localparam logic [1:0] CMD_IGNORED = 2'd3;  // no meaning, must be dropped
  localparam int unsigned RANDOM_REQUESTS = 380;

  typedef struct {
    logic [31:0] index;
    logic [31:0] distance;
    logic        is_last;
  } neighbour_t;

  class neighbour_scoreboard;
    logic [31:0] held_distance[MAX_K];
    logic [31:0] held_index[MAX_K];
    int unsigned held_count;
    logic [31:0] query_id;
    logic [6:0]  k_setting;
    neighbour_t  expected_neighbours[$];
    int unsigned mismatches;
    int unsigned neighbours_checked;
    int unsigned finishes;

    function new();
      held_count = 0;
      query_id = '0;
      k_setting = 7'd32;
      mismatches = 0;
      neighbours_checked = 0;
      finishes = 0;
    endfunction

    function void set_k(logic [6:0] value);
      k_setting = value;
    endfunction

    function int unsigned pending();
      return expected_neighbours.size();
    endfunction

    // ranking is by distance first, then by neighbour index
    function bit ranks_further(logic [31:0] da, logic [31:0] ia,
                               logic [31:0] db, logic [31:0] ib);
      if (da != db) return da > db;
      return ia > ib;
    endfunction

    function int unsigned furthest_slot();
      int unsigned best = 0;
      for (int unsigned s = 1; s < held_count; s++)
        if (ranks_further(held_distance[s], held_index[s],
                          held_distance[best], held_index[best]))
          best = s;
      return best;
    endfunction

    function void note_request(logic [1:0] cmd, logic [31:0] id, logic [31:0] distance);
      int unsigned k_eff;
      int unsigned f;
      int unsigned top;
      neighbour_t n;
      k_eff = (k_setting > MAX_K) ? MAX_K : k_setting;
      case (cmd)
        CMD_BEGIN: begin
          held_count = 0;
          query_id = id;
        end
        CMD_OFFER: begin
          if (id != query_id) begin
            if (held_count < k_eff) begin
              held_distance[held_count] = distance;
              held_index[held_count] = id - 32'd1;
              held_count++;
            end else if (held_count > 0) begin
              f = furthest_slot();
              if (held_distance[f] > distance) begin
                held_distance[f] = distance;
                held_index[f] = id - 32'd1;
              end
            end
          end
        end
        CMD_FINISH: begin
          finishes++;
          while (held_count > 0) begin
            f = furthest_slot();
            top = held_count - 1;
            n.index = held_index[f];
            n.distance = held_distance[f];
            n.is_last = (held_count == 1);
            expected_neighbours = {expected_neighbours, n};
            held_distance[f] = held_distance[top];
            held_index[f] = held_index[top];
            held_count = top;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_neighbour(logic [31:0] index, logic [31:0] distance, logic is_last);
      neighbour_t want;
      neighbours_checked++;
      if (expected_neighbours.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected neighbour index %h distance %h last %b",
                   $time, index, distance, is_last);
        return;
      end
      want = expected_neighbours.pop_front();
      if (want.index !== index || want.distance !== distance || want.is_last !== is_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: neighbour differs: expected %h/%h/%b got %h/%h/%b", $time,
                   want.index, want.distance, want.is_last, index, distance, is_last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [31:0] item_id, [63:32] distance
  logic [1:0]  in_tuser = '0;   // [1:0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [31:0] neighbour_index, [63:32] neighbour_distance
  logic        out_tlast;

  neighbour_scoreboard sb;
  bit          quiet = 1'b0;
  int unsigned requests_sent = 0;
  int unsigned k_writes = 0;

  top_k_nearest_selector_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit take_break();
    return !quiet && ($urandom_range(99) < 6);
  endfunction

  always @(negedge clk) begin
    out_tready = !take_break();
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_neighbour(out_tdata[31:0], out_tdata[63:32], out_tlast);
  end

  task automatic send_request(input logic [1:0] cmd, input logic [31:0] id,
                              input logic [31:0] distance);
    @(negedge clk);
    while (take_break()) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {distance, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(cmd, id, distance);
    if (cmd != CMD_IGNORED) requests_sent++;
  endtask

  // drop valid, drain all queued neighbours, then let the chain go quiet
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_k(input logic [6:0] value);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_k(value);
    k_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [6:0] pick_k();
    case ($urandom_range(11))
      0: return 7'd1;
      1: return 7'd64;
      2: return 7'd127;
      3: return 7'($urandom_range(65, 126));
      4: return 7'd0;
      default: return 7'($urandom_range(2, 20));
    endcase
  endfunction

  // one query: begin, a run of candidates, finish; now and then broken
  task automatic random_phase(input int unsigned n_offers);
    logic [31:0] qid;
    logic [31:0] id;
    logic [31:0] distance;
    bit tiny_ids;
    bit tiny_dist;
    int unsigned split;
    tiny_ids = $urandom_range(1);
    tiny_dist = ($urandom_range(2) == 0);
    qid = tiny_ids ? 32'($urandom_range(1, 24)) : $urandom();
    // occasionally change k in the middle of the query
    split = ($urandom_range(9) == 0) ? $urandom_range(n_offers) : n_offers + 1;
    if ($urandom_range(19) != 0) send_request(CMD_BEGIN, qid, $urandom());
    for (int unsigned i = 0; i < n_offers; i++) begin
      if (i == split) write_k(pick_k());
      id = tiny_ids ? 32'($urandom_range(0, 24)) : $urandom();
      if ($urandom_range(15) == 0) id = qid;
      distance = tiny_dist ? 32'($urandom_range(0, 5)) : $urandom();
      case ($urandom_range(24))
        0: send_request(CMD_IGNORED, $urandom(), $urandom());
        1: send_request(CMD_FINISH, $urandom(), $urandom());
        default: send_request(CMD_OFFER, id, distance);
      endcase
    end
    if ($urandom_range(9) != 0) send_request(CMD_FINISH, $urandom(), $urandom());
  endtask

  initial begin
    int unsigned random_start;
    int unsigned done;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: before any begin the query id is zero, so id zero is skipped
    send_request(CMD_OFFER, 32'd0, 32'd5);
    send_request(CMD_OFFER, 32'd1, 32'hFFFF_FFFF);
    send_request(CMD_FINISH, 32'd0, 32'd0);
    send_request(CMD_FINISH, 32'd0, 32'd0);           // nothing held
    send_request(CMD_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_BEGIN, 32'hFFFF_FFFF, 32'd0);
    send_request(CMD_OFFER, 32'hFFFF_FFFF, 32'd3);    // self, skipped
    send_request(CMD_OFFER, 32'd0, 32'd0);            // index wraps
    send_request(CMD_OFFER, 32'd7, 32'd100);
    send_request(CMD_OFFER, 32'd3, 32'd100);          // tie broken on index
    send_request(CMD_OFFER, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(CMD_FINISH, 32'd0, 32'd0);
    write_k(7'd1);
    send_request(CMD_BEGIN, 32'd5, 32'd0);
    send_request(CMD_OFFER, 32'd2, 32'd50);
    send_request(CMD_OFFER, 32'd3, 32'd50);           // equal, no replace
    send_request(CMD_OFFER, 32'd4, 32'd49);
    send_request(CMD_FINISH, 32'd0, 32'd0);
    write_k(7'd3);
    send_request(CMD_BEGIN, 32'd9, 32'd0);
    send_request(CMD_OFFER, 32'd10, 32'd8);
    send_request(CMD_OFFER, 32'd11, 32'd6);
    send_request(CMD_OFFER, 32'd12, 32'd7);
    write_k(7'd0);                                    // k below fill level
    send_request(CMD_OFFER, 32'd13, 32'd7);
    send_request(CMD_OFFER, 32'd14, 32'd9);
    send_request(CMD_FINISH, 32'd0, 32'd0);

    // random part; the first phases overfill a full-size store
    random_start = requests_sent;
    write_k(7'd127);
    random_phase(75);
    write_k(7'd64);
    random_phase(70);
    done = requests_sent - random_start;
    while (done < RANDOM_REQUESTS) begin
      quiet = (done >= 200 && done < 290);
      if ($urandom_range(2) == 0) write_k(pick_k());
      random_phase(($urandom_range(9) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 14));
      done = requests_sent - random_start;
    end
    quiet = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    $display("run covered %0d requests, %0d finishes and %0d k writes;",
             requests_sent, sb.finishes, k_writes);
    $display("%0d neighbours checked, %0d mismatches", sb.neighbours_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout, %0d neighbours still expected", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ top_k_nearest_selector_unit.f @@
rtl/tkns_pkg.sv
rtl/tkns_cell.sv
rtl/tkns_chain.sv
rtl/top_k_nearest_selector_unit.sv
tb/tb_top_k_nearest_selector_unit.sv
